FILE: hdl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared constants, byte classes and the result burst type of the UTF-8
// stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] ReplChar  = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MaxScalar = 21'h10FFFF;
  localparam logic [CpWidth-1:0] Max1Byte  = 21'h00007F;
  localparam logic [CpWidth-1:0] Max2Byte  = 21'h0007FF;
  localparam logic [CpWidth-1:0] Max3Byte  = 21'h00FFFF;

  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] Seq2    = 3'd2;
  localparam logic [2:0] Seq3    = 3'd3;
  localparam logic [2:0] Seq4    = 3'd4;

  localparam logic [2:0] MaxBurst = 3'd4;

  typedef enum logic [2:0] {
    BkAscii,
    BkBad,
    BkCont,
    BkLead2,
    BkLead3,
    BkLead4
  } byte_kind_e;

  // cnt items per byte; all but the last are U+FFFD
  typedef struct packed {
    logic [2:0]         cnt;
    logic [CpWidth-1:0] tail_cp;
    logic               tail_rep;
  } burst_t;

  function automatic byte_kind_e classify(input logic [7:0] b);
    byte_kind_e k;
    if (b[7] == 1'b0) begin
      k = BkAscii;
    end else if (b == 8'hC0 || b == 8'hC1 || b >= 8'hF5) begin
      k = BkBad;
    end else if (b[7:6] == 2'b10) begin
      k = BkCont;
    end else if (b[7:5] == 3'b110) begin
      k = BkLead2;
    end else if (b[7:4] == 4'b1110) begin
      k = BkLead3;
    end else begin
      k = BkLead4;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8sd_core.sv
// ----------------------------------------------------------------------------
// utf8sd_core
// Sequence state (length, bytes held, accumulator) and the per-byte decode
// that yields the burst of results for one input item.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        byte_i,
  output utf8sd_pkg::burst_t     burst_o
);

  logic [2:0]  len_q, len_d;
  logic [1:0]  held_q, held_d;
  logic [20:0] acc_q, acc_d;

  utf8sd_pkg::byte_kind_e kind;
  logic [20:0] acc_shift;
  logic [1:0]  held_inc;
  logic [2:0]  pre_cnt;
  logic        bad;

  always_comb begin
    kind      = utf8sd_pkg::classify(byte_i);
    acc_shift = {acc_q[14:0], byte_i[5:0]};
    held_inc  = held_q + 2'd1;
    pre_cnt   = 3'd0;
    bad       = 1'b0;
    len_d     = len_q;
    held_d    = held_q;
    acc_d     = acc_q;
    burst_o.cnt      = 3'd0;
    burst_o.tail_cp  = utf8sd_pkg::ReplChar;
    burst_o.tail_rep = 1'b1;

    if (len_q != utf8sd_pkg::SeqNone && kind == utf8sd_pkg::BkCont) begin
      acc_d  = acc_shift;
      held_d = held_inc;
      if (held_inc == 2'd0 || {1'b0, held_inc} >= len_q) begin
        bad = (len_q == utf8sd_pkg::Seq2 && acc_shift <= utf8sd_pkg::Max1Byte) ||
              (len_q == utf8sd_pkg::Seq3 && acc_shift <= utf8sd_pkg::Max2Byte) ||
              (len_q == utf8sd_pkg::Seq4 && acc_shift <= utf8sd_pkg::Max3Byte) ||
              (acc_shift > utf8sd_pkg::MaxScalar);
        if (bad) begin
          burst_o.cnt = len_q;
        end else begin
          burst_o.cnt      = 3'd1;
          burst_o.tail_cp  = acc_shift;
          burst_o.tail_rep = 1'b0;
        end
        len_d  = utf8sd_pkg::SeqNone;
        held_d = 2'd0;
        acc_d  = '0;
      end
    end else begin
      // no continuation for an open sequence: one replacement per held byte, then byte afresh
      if (len_q != utf8sd_pkg::SeqNone) begin
        pre_cnt = {1'b0, held_q};
      end
      len_d  = utf8sd_pkg::SeqNone;
      held_d = 2'd0;
      acc_d  = '0;
      burst_o.cnt = pre_cnt;
      case (kind)
        utf8sd_pkg::BkAscii: begin
          burst_o.cnt      = pre_cnt + 3'd1;
          burst_o.tail_cp  = {13'd0, byte_i};
          burst_o.tail_rep = 1'b0;
        end
        utf8sd_pkg::BkLead2: begin
          len_d  = utf8sd_pkg::Seq2;
          held_d = 2'd1;
          acc_d  = {16'd0, byte_i[4:0]};
        end
        utf8sd_pkg::BkLead3: begin
          len_d  = utf8sd_pkg::Seq3;
          held_d = 2'd1;
          acc_d  = {17'd0, byte_i[3:0]};
        end
        utf8sd_pkg::BkLead4: begin
          len_d  = utf8sd_pkg::Seq4;
          held_d = 2'd1;
          acc_d  = {18'd0, byte_i[2:0]};
        end
        default: begin
          burst_o.cnt = pre_cnt + 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= utf8sd_pkg::SeqNone;
      held_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept_i) begin
      len_q  <= len_d;
      held_q <= held_d;
      acc_q  <= acc_d;
    end
  end

`ifndef SYNTH
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q == utf8sd_pkg::SeqNone || len_q == utf8sd_pkg::Seq2 ||
    len_q == utf8sd_pkg::Seq3 || len_q == utf8sd_pkg::Seq4)
    else $error("bad sequence length");

  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != utf8sd_pkg::SeqNone |-> held_q != 2'd0 && {1'b0, held_q} < len_q)
    else $error("held count outside open sequence");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q == utf8sd_pkg::SeqNone |-> held_q == 2'd0 && acc_q == '0)
    else $error("stale state with no open sequence");
`endif

endmodule

`default_nettype wire

FILE: hdl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to Unicode code point decoder with U+FFFD replacement.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per item on in_byte_i (in_valid_i/in_stall_o).
// Output channel: code_point_o, replaced_o, last_of_run_o (out_valid_o/
// out_stall_i). Each byte gives 0 to 4 result items; last_of_run_o marks the
// final one of a byte. Lead bytes give none unless they break an open sequence;
// non-final continuations give none. Latency: results of a byte appear the cycle after it is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and
// out_stall_i is low. A byte with several results holds the output register;
// the next byte is taken in the cycle its last result leaves. The limit is the
// single result register, one item a cycle while out_stall_i is low.
// Reset (rst_ni low, asynchronous) closes any open sequence and drops
// undelivered results. While out_stall_i is high the current result holds
// and in_stall_o is raised once no more results may be queued.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [20:0]      code_point_o,
  output logic             replaced_o,
  output logic             last_of_run_o
);

  utf8sd_pkg::burst_t burst;

  logic [2:0]  cnt_q, cnt_d;
  logic [20:0] tail_cp_q;
  logic        tail_rep_q;
  logic        in_accept;
  logic        pop;

  assign out_valid_o   = (cnt_q != 3'd0);
  assign pop           = out_valid_o && !out_stall_i;
  assign in_stall_o    = (cnt_q > 3'd1) || (cnt_q == 3'd1 && out_stall_i);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign last_of_run_o = (cnt_q == 3'd1);
  assign code_point_o  = last_of_run_o ? tail_cp_q : utf8sd_pkg::ReplChar;
  assign replaced_o    = last_of_run_o ? tail_rep_q : 1'b1;

  utf8sd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_byte_i),
    .burst_o  (burst)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (in_accept) begin
      cnt_d = burst.cnt;
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tail_cp_q  <= burst.tail_cp;
      tail_rep_q <= burst.tail_rep;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= utf8sd_pkg::MaxBurst)
    else $error("burst count out of range");

  a_lead_items_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> replaced_o && code_point_o == utf8sd_pkg::ReplChar)
    else $error("non-final item is not a replacement");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !last_of_run_o |=> out_valid_o)
    else $error("burst ended before its final item");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Drives UTF-8 bytes into the decoder and checks every decoded code point.
// A directed run covers the range ends, invalid and stray bytes, overlong,
// too large and broken sequences. A random run follows, made mostly of valid
// sequences of every length plus noise. A local decoder predicts each item;
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

  typedef struct packed {
    logic [utf8sd_pkg::CpWidth-1:0] cp;
    logic                           rep;
    logic                           last;
  } decoded_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  in_byte_i    = 8'h00;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [20:0] code_point_o;
  logic        replaced_o;
  logic        last_of_run_o;

  logic [7:0]                     byte_stream[$];
  decoded_t                       decoded_q[$];
  logic [2:0]                     open_len = utf8sd_pkg::SeqNone;
  logic [1:0]                     held     = 2'd0;
  logic [utf8sd_pkg::CpWidth-1:0] acc      = '0;
  bit                             byte_taken   = 1'b0;
  bit                             result_taken = 1'b0;
  bit                             tx_calm = 1'b0;
  bit                             rx_calm = 1'b1;
  int                             tx_wait = 0;
  int                             rx_wait = 0;
  int                             errors  = 0;

  utf8_stream_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic void expect_cp(input logic [utf8sd_pkg::CpWidth-1:0] cp,
                                    input logic rep);
    decoded_q.push_back('{cp: cp, rep: rep, last: 1'b0});
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    utf8sd_pkg::byte_kind_e         kind;
    logic [utf8sd_pkg::CpWidth-1:0] acc_n;
    logic [1:0]                     held_n;
    int                             n0;
    bit                             bad;
    n0 = decoded_q.size();
    if (b[7] == 1'b0) kind = utf8sd_pkg::BkAscii;
    else if (b == 8'hC0 || b == 8'hC1 || b >= 8'hF5) kind = utf8sd_pkg::BkBad;
    else if (b[7:6] == 2'b10) kind = utf8sd_pkg::BkCont;
    else if (b[7:5] == 3'b110) kind = utf8sd_pkg::BkLead2;
    else if (b[7:4] == 4'b1110) kind = utf8sd_pkg::BkLead3;
    else kind = utf8sd_pkg::BkLead4;

    if (open_len != utf8sd_pkg::SeqNone) begin
      if (kind == utf8sd_pkg::BkCont) begin
        acc_n  = {acc[utf8sd_pkg::CpWidth-7:0], b[5:0]};
        held_n = held + 2'd1;
        if (held_n != 2'd0 && {1'b0, held_n} < open_len) begin
          acc  = acc_n;
          held = held_n;
          return;
        end
        bad = (acc_n > utf8sd_pkg::MaxScalar) ||
              (open_len == utf8sd_pkg::Seq2 && acc_n <= utf8sd_pkg::Max1Byte) ||
              (open_len == utf8sd_pkg::Seq3 && acc_n <= utf8sd_pkg::Max2Byte) ||
              (open_len == utf8sd_pkg::Seq4 && acc_n <= utf8sd_pkg::Max3Byte);
        if (bad) begin
          for (int i = 0; i < open_len; i++) expect_cp(utf8sd_pkg::ReplChar, 1'b1);
        end else begin
          expect_cp(acc_n, 1'b0);
        end
        open_len = utf8sd_pkg::SeqNone;
        held     = 2'd0;
        acc      = '0;
        decoded_q[decoded_q.size()-1].last = 1'b1;
        return;
      end
      for (int i = 0; i < held; i++) expect_cp(utf8sd_pkg::ReplChar, 1'b1);
      open_len = utf8sd_pkg::SeqNone;
      held     = 2'd0;
      acc      = '0;
    end

    case (kind)
      utf8sd_pkg::BkAscii: expect_cp({13'd0, b}, 1'b0);
      utf8sd_pkg::BkBad, utf8sd_pkg::BkCont: expect_cp(utf8sd_pkg::ReplChar, 1'b1);
      utf8sd_pkg::BkLead2: begin
        open_len = utf8sd_pkg::Seq2;
        held     = 2'd1;
        acc      = {16'd0, b[4:0]};
      end
      utf8sd_pkg::BkLead3: begin
        open_len = utf8sd_pkg::Seq3;
        held     = 2'd1;
        acc      = {17'd0, b[3:0]};
      end
      default: begin
        open_len = utf8sd_pkg::Seq4;
        held     = 2'd1;
        acc      = {18'd0, b[2:0]};
      end
    endcase
    if (decoded_q.size() > n0) decoded_q[decoded_q.size()-1].last = 1'b1;
  endfunction

  // sample at the rising edge: check results first, then predict the new byte
  always @(posedge clk_i) begin : monitor
    decoded_t want;
    byte_taken   = 1'b0;
    result_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        result_taken = 1'b1;
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: code_point %h replaced %b last %b",
                   $time, code_point_o, replaced_o, last_of_run_o);
        end else begin
          want = decoded_q.pop_front();
          if (code_point_o !== want.cp) begin
            errors++;
            $display("%0t: code_point expected %h actual %h", $time, want.cp, code_point_o);
          end
          if (replaced_o !== want.rep) begin
            errors++;
            $display("%0t: replaced expected %b actual %b", $time, want.rep, replaced_o);
          end
          if (last_of_run_o !== want.last) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b",
                     $time, want.last, last_of_run_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        byte_taken = 1'b1;
        decode_byte(in_byte_i);
      end
    end
  end

  always @(negedge clk_i) begin : byte_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || byte_taken) begin
      if (tx_wait > 0) begin
        in_valid_i <= 1'b0;
        tx_wait    <= tx_wait - 1;
      end else if (byte_stream.size() > 0) begin
        in_byte_i  <= byte_stream.pop_front();
        in_valid_i <= 1'b1;
        tx_wait    <= draw_wait(tx_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : result_sink
    int w;
    w = result_taken ? draw_wait(rx_calm) : rx_wait;
    if (rst_ni && w > 0) begin
      out_stall_i <= 1'b1;
      rx_wait     <= w - 1;
    end else begin
      out_stall_i <= 1'b0;
      rx_wait     <= 0;
    end
  end

  initial begin : stimulus
    logic [utf8sd_pkg::CpWidth-1:0] cp;
    logic [7:0]                     lead;
    int                             len;
    int                             ncont;

    byte_stream = '{
      8'h00, 8'h7F,
      8'hC2, 8'h80,
      8'hF4, 8'h8F, 8'hBF, 8'hBF,
      8'hC0, 8'hFF, 8'h80,
      8'hE0, 8'h80, 8'h80,
      8'hF4, 8'h90, 8'h80, 8'h80,
      8'hED, 8'hA0, 8'h80,
      8'hE2, 8'h82, 8'h41,
      8'hF0, 8'h90, 8'h80, 8'hC2
    };

    while (byte_stream.size() < 100) begin
      case ($urandom_range(0, 9))
        0, 1: byte_stream.push_back(8'($urandom_range(0, 127)));
        2, 3, 4, 5, 6: begin
          len = $urandom_range(2, 4);
          if (len == 2) begin
            cp = 21'($urandom_range(32'h80, 32'h7FF));
            byte_stream.push_back({3'b110, cp[10:6]});
          end else if (len == 3) begin
            cp = 21'($urandom_range(32'h800, 32'hFFFF));
            byte_stream.push_back({4'b1110, cp[15:12]});
            byte_stream.push_back({2'b10, cp[11:6]});
          end else begin
            cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
            byte_stream.push_back({5'b11110, cp[20:18]});
            byte_stream.push_back({2'b10, cp[17:12]});
            byte_stream.push_back({2'b10, cp[11:6]});
          end
          byte_stream.push_back({2'b10, cp[5:0]});
        end
        7, 9: begin
          // any lead with random continuations; a short tail leaves it broken
          lead  = 8'($urandom_range(8'hC2, 8'hF4));
          ncont = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
          byte_stream.push_back(lead);
          if (byte_stream.size() % 2 == 0) ncont = $urandom_range(0, ncont - 1);
          for (int i = 0; i < ncont; i++)
            byte_stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        default: byte_stream.push_back(8'($urandom_range(0, 255)));
      endcase
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    for (int i = 0; i < 2000 && decoded_q.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      errors++;
      $display("%0t: %0d items never arrived, next expected %h",
               $time, decoded_q.size(), decoded_q[0].cp);
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
